@@ sv/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and helpers for the stuffed frame receiver
// This package holds the register set, the event word that passes from the
// deframer to the report stage, the status codes and the CRC-16/ARC byte step.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned MaxFrameBytes = 255;
  localparam int unsigned MinFrameBytes = 58;
  localparam logic [7:0]  XorMask       = 8'h20;
  localparam logic [15:0] CrcPoly       = 16'hA001;
  localparam logic [7:0]  Broadcast     = 8'hFF;

  // Frame status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_LEN = 3'd1;
  localparam logic [2:0] ST_BAD_VER = 3'd2;
  localparam logic [2:0] ST_BAD_CRC = 3'd3;
  localparam logic [2:0] ST_ABORT   = 3'd4;

  // Item kinds.
  localparam logic KIND_BODY   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Register indexes.
  localparam logic [2:0] REG_START_FIRST  = 3'd0;
  localparam logic [2:0] REG_START_SECOND = 3'd1;
  localparam logic [2:0] REG_ESCAPE       = 3'd2;
  localparam logic [2:0] REG_VERSION      = 3'd3;
  localparam logic [2:0] REG_OWN_ADDR     = 3'd4;
  localparam logic [2:0] REG_ACK_KIND     = 3'd5;

  typedef struct packed {
    logic [7:0] start_first;
    logic [7:0] start_second;
    logic [7:0] escape_code;
    logic [7:0] version_expected;
    logic [7:0] own_address;
    logic [7:0] ack_kind_code;
  } cfg_t;

  typedef struct packed {
    logic       item_kind;
    logic [2:0] status;
    logic [7:0] index;
    logic [7:0] value;
    logic [7:0] msg_kind;
    logic [7:0] dest_addr;
    logic [7:0] src_addr;
    logic [7:0] key_index;
    logic [7:0] frame_length;
  } event_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One byte of CRC-16/ARC, reflected.
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (v[0]) v = (v >> 1) ^ CrcPoly;
      else      v = v >> 1;
    end
    return v;
  endfunction

endpackage

@@ sv/stuffed_frame_receiver_crc16_unit.sv @@
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_crc16_unit: byte-stuffed frame receiver, CRC-16/ARC
// Deframes raw line bytes, emits body bytes and one report per frame.
// ----------------------------------------------------------------------------
// The unit takes one raw line byte per cycle, unless the event queue is full,
// and gives zero or one result per byte: the deframer computes its whole CRC
// byte step and state update combinationally. A result passes through a queue
// entry, then the output register, and the two-entry queue between the deframer
// and the output register lets the input keep flowing while a result waits.
// Registers are written over the APB port at byte address 4*index and should be
// changed only while no frame is in flight.
module stuffed_frame_receiver_crc16_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_item_kind,
  output logic [7:0]  out_body_index,
  output logic [7:0]  out_body_value,
  output logic [2:0]  out_frame_status,
  output logic        out_for_this_node,
  output logic        out_is_ack,
  output logic [7:0]  out_msg_kind,
  output logic [7:0]  out_dest_addr,
  output logic [7:0]  out_src_addr,
  output logic [7:0]  out_key_index,
  output logic [7:0]  out_frame_length
);

  sfr_pkg::cfg_t    cfg_r, cfg_nxt;
  sfr_pkg::event_t  f_ev, q_ev, o_ev;
  sfr_pkg::q_stat_t q_stat;
  logic             f_push, q_pop, in_acc;
  logic [2:0]       reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        sfr_pkg::REG_START_FIRST:  cfg_nxt.start_first      = pwdata[7:0];
        sfr_pkg::REG_START_SECOND: cfg_nxt.start_second     = pwdata[7:0];
        sfr_pkg::REG_ESCAPE:       cfg_nxt.escape_code      = pwdata[7:0];
        sfr_pkg::REG_VERSION:      cfg_nxt.version_expected = pwdata[7:0];
        sfr_pkg::REG_OWN_ADDR:     cfg_nxt.own_address      = pwdata[7:0];
        sfr_pkg::REG_ACK_KIND:     cfg_nxt.ack_kind_code    = pwdata[7:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_first      <= 8'd222;
      cfg_r.start_second     <= 8'd173;
      cfg_r.escape_code      <= 8'd125;
      cfg_r.version_expected <= 8'd1;
      cfg_r.own_address      <= 8'd0;
      cfg_r.ack_kind_code    <= 8'd65;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      sfr_pkg::REG_START_FIRST:  prdata = {24'h0, cfg_r.start_first};
      sfr_pkg::REG_START_SECOND: prdata = {24'h0, cfg_r.start_second};
      sfr_pkg::REG_ESCAPE:       prdata = {24'h0, cfg_r.escape_code};
      sfr_pkg::REG_VERSION:      prdata = {24'h0, cfg_r.version_expected};
      sfr_pkg::REG_OWN_ADDR:     prdata = {24'h0, cfg_r.own_address};
      sfr_pkg::REG_ACK_KIND:     prdata = {24'h0, cfg_r.ack_kind_code};
      default:                   prdata = 32'h0;
    endcase
  end

  assign in_ready = !q_stat.full;
  assign in_acc   = in_valid && in_ready;

  sfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .byte_valid (in_acc),
    .byte_in    (in_rx_byte),
    .ev_push    (f_push),
    .ev         (f_ev)
  );

  sfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (f_ev),
    .pop       (q_pop),
    .pop_data  (q_ev),
    .stat      (q_stat)
  );

  sfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ev_avail  (!q_stat.empty),
    .ev        (q_ev),
    .ev_take   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ev    (o_ev),
    .out_mine  (out_for_this_node),
    .out_ack   (out_is_ack)
  );

  assign out_item_kind    = o_ev.item_kind;
  assign out_body_index   = o_ev.index;
  assign out_body_value   = o_ev.value;
  assign out_frame_status = o_ev.status;
  assign out_msg_kind     = o_ev.msg_kind;
  assign out_dest_addr    = o_ev.dest_addr;
  assign out_src_addr     = o_ev.src_addr;
  assign out_key_index    = o_ev.key_index;
  assign out_frame_length = o_ev.frame_length;

  // Body words carry no status and no flags.
  a_body_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == sfr_pkg::KIND_BODY |->
      out_frame_status == sfr_pkg::ST_OK && !out_is_ack && !out_for_this_node)
    else $error("body word carries report fields");

  // Flags only on good frames.
  a_flags_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status != sfr_pkg::ST_OK |-> !out_is_ack && !out_for_this_node)
    else $error("flags set on a failed frame");

  // A full queue never takes a push.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full && !q_pop |-> !f_push)
    else $error("event queue overflow");

  // Queue empty means the output stage pulls nothing.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !q_pop)
    else $error("event queue underflow");

endmodule

@@ sv/sfr_front.sv @@
// ----------------------------------------------------------------------------
// sfr_front: deframer front end
// Hunts for the start bytes, unstuffs, tracks position and CRC, stores the
// header and emits one event word per body byte or frame end.
// ----------------------------------------------------------------------------
module sfr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  sfr_pkg::cfg_t       cfg,
  input  logic                byte_valid,
  input  logic [7:0]          byte_in,
  output logic                ev_push,
  output sfr_pkg::event_t     ev
);

  localparam logic [1:0] MODE_HUNT   = 2'd0;
  localparam logic [1:0] MODE_SECOND = 2'd1;
  localparam logic [1:0] MODE_FRAME  = 2'd2;

  logic [1:0]  mode_r, mode_nxt;
  logic        esc_r, esc_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  hdr_r [6];
  logic [7:0]  hdr_nxt [6];

  logic [7:0]  d;
  logic [7:0]  rep_pos;
  logic [7:0]  len_m2;
  logic        rep;
  logic [2:0]  rep_status;

  // Per-byte frame state update.
  always_comb begin
    mode_nxt   = mode_r;
    esc_nxt    = esc_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    for (int i = 0; i < 6; i++) hdr_nxt[i] = hdr_r[i];
    d          = byte_in;
    rep_pos    = pos_r;
    rep        = 1'b0;
    rep_status = sfr_pkg::ST_OK;
    len_m2     = hdr_r[1] - 8'd2;
    ev_push    = 1'b0;
    ev         = '0;

    if (byte_valid) begin
      if (mode_r == MODE_SECOND) begin
        if (byte_in == cfg.start_second) begin
          crc_nxt  = sfr_pkg::crc_step(crc_r, byte_in);
          pos_nxt  = 8'd2;
          mode_nxt = MODE_FRAME;
        end else begin
          mode_nxt = MODE_HUNT;
          esc_nxt  = 1'b0;
          pos_nxt  = '0;
          crc_nxt  = '0;
        end
      end else if (mode_r != MODE_FRAME) begin
        if (byte_in == cfg.start_first) begin
          esc_nxt  = 1'b0;
          crc_nxt  = sfr_pkg::crc_step(16'h0000, byte_in);
          pos_nxt  = 8'd1;
          mode_nxt = MODE_SECOND;
        end
      end else if (byte_in == cfg.start_first || byte_in == cfg.start_second) begin
        // A raw start byte aborts the frame.
        rep        = 1'b1;
        rep_status = sfr_pkg::ST_ABORT;
        esc_nxt    = 1'b0;
        if (byte_in == cfg.start_first) begin
          crc_nxt  = sfr_pkg::crc_step(16'h0000, byte_in);
          pos_nxt  = 8'd1;
          mode_nxt = MODE_SECOND;
        end else begin
          crc_nxt  = '0;
          pos_nxt  = '0;
          mode_nxt = MODE_HUNT;
        end
      end else if (!esc_r && byte_in == cfg.escape_code) begin
        esc_nxt = 1'b1;
      end else begin
        if (esc_r) d = byte_in ^ sfr_pkg::XorMask;
        esc_nxt = 1'b0;
        if (pos_r >= 8'd2 && pos_r <= 8'd7) hdr_nxt[pos_r[2:0] - 3'd2] = d;
        pos_nxt = pos_r + 8'd1;
        rep_pos = pos_r + 8'd1;
        if (pos_r < 8'd8) begin
          crc_nxt = sfr_pkg::crc_step(crc_r, d);
          if (pos_r == 8'd3 && (d < 8'(sfr_pkg::MinFrameBytes) ||
                                d > 8'(sfr_pkg::MaxFrameBytes))) begin
            rep        = 1'b1;
            rep_status = sfr_pkg::ST_BAD_LEN;
            mode_nxt   = MODE_HUNT;
            pos_nxt    = '0;
            crc_nxt    = '0;
          end
        end else if (pos_r < len_m2) begin
          crc_nxt     = sfr_pkg::crc_step(crc_r, d);
          ev_push     = 1'b1;
          ev.item_kind = sfr_pkg::KIND_BODY;
          ev.index    = pos_r;
          ev.value    = d;
        end else if (pos_r == len_m2) begin
          crc_lo_nxt = d;
        end else begin
          // High CRC byte closes the frame.
          rep = 1'b1;
          if (hdr_r[0] != cfg.version_expected) rep_status = sfr_pkg::ST_BAD_VER;
          else if ({d, crc_lo_r} != crc_r)       rep_status = sfr_pkg::ST_BAD_CRC;
          else                                   rep_status = sfr_pkg::ST_OK;
          mode_nxt = MODE_HUNT;
          pos_nxt  = '0;
          crc_nxt  = '0;
        end
      end

      // Report word; header bytes not yet received read as zero.
      if (rep) begin
        ev_push         = 1'b1;
        ev.item_kind    = sfr_pkg::KIND_REPORT;
        ev.status       = rep_status;
        ev.frame_length = (rep_pos > 8'd3) ? hdr_nxt[1] : 8'h00;
        ev.msg_kind     = (rep_pos > 8'd4) ? hdr_nxt[2] : 8'h00;
        ev.dest_addr    = (rep_pos > 8'd5) ? hdr_nxt[3] : 8'h00;
        ev.src_addr     = (rep_pos > 8'd6) ? hdr_nxt[4] : 8'h00;
        ev.key_index    = (rep_pos > 8'd7) ? hdr_nxt[5] : 8'h00;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_HUNT;
      esc_r    <= 1'b0;
      pos_r    <= '0;
      crc_r    <= '0;
      crc_lo_r <= '0;
    end else begin
      mode_r   <= mode_nxt;
      esc_r    <= esc_nxt;
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  // Header store, no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) hdr_r[i] <= hdr_nxt[i];
  end

endmodule

@@ sv/sfr_queue.sv @@
// ----------------------------------------------------------------------------
// sfr_queue: two-entry event queue
// Decouples the deframer from the report stage so each can stall on its own.
// ----------------------------------------------------------------------------
module sfr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sfr_pkg::event_t  push_data,
  input  logic             pop,
  output sfr_pkg::event_t  pop_data,
  output sfr_pkg::q_stat_t stat
);

  sfr_pkg::event_t mem_r [2];
  logic            wr_r, wr_nxt;
  logic            rd_r, rd_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign pop_data   = mem_r[rd_r];

  // Pointer and count update.
  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop  ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

@@ sv/sfr_back.sv @@
// ----------------------------------------------------------------------------
// sfr_back: report stage and output register
// Derives the acknowledge and address-match flags and holds the result word.
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sfr_pkg::cfg_t    cfg,
  input  logic             ev_avail,
  input  sfr_pkg::event_t  ev,
  output logic             ev_take,
  output logic             out_valid,
  input  logic             out_ready,
  output sfr_pkg::event_t  out_ev,
  output logic             out_mine,
  output logic             out_ack
);

  logic            valid_r, valid_nxt;
  sfr_pkg::event_t ev_r;
  logic            mine_r, ack_r;
  logic            ack_c, mine_c, ok;

  assign ev_take = ev_avail && (!valid_r || out_ready);

  // Flags apply only to good frame reports.
  always_comb begin
    ok     = (ev.item_kind == sfr_pkg::KIND_REPORT) && (ev.status == sfr_pkg::ST_OK);
    ack_c  = ok && (ev.msg_kind == cfg.ack_kind_code);
    mine_c = ok && (ev.dest_addr == cfg.own_address || ev.dest_addr == sfr_pkg::Broadcast)
                && !(ack_c && ev.src_addr == cfg.own_address);
    valid_nxt = ev_take ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (ev_take) begin
      ev_r   <= ev;
      mine_r <= mine_c;
      ack_r  <= ack_c;
    end
  end

  assign out_valid = valid_r;
  assign out_ev    = ev_r;
  assign out_mine  = mine_r;
  assign out_ack   = ack_r;

endmodule

@@ sim/tb_stuffed_frame_receiver_crc16_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stuffed_frame_receiver_crc16_unit: self-checking bench for the receiver
// Sends raw line bytes (short directed sequences, then stuffed frames with
// random content, broken frames and noise) over several register settings,
// predicts every body word and frame report, and checks each output word.
// ----------------------------------------------------------------------------
module tb_stuffed_frame_receiver_crc16_unit;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 20;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] body_index;
    logic [7:0] body_value;
    logic [2:0] frame_status;
    logic       for_this_node;
    logic       is_ack;
    logic [7:0] msg_kind;
    logic [7:0] dest_addr;
    logic [7:0] src_addr;
    logic [7:0] key_index;
    logic [7:0] frame_length;
  } rx_word_t;

  // Predicts deframer output words and checks them in order.
  class frame_scoreboard;
    localparam logic [1:0] HUNT_FIRST = 2'd0;
    localparam logic [1:0] HUNT_SECOND = 2'd1;
    localparam logic [1:0] IN_FRAME = 2'd2;

    logic [7:0]  sf, ss, esc, ver, own, ack;
    logic [1:0]  mode;
    logic        esc_pend;
    logic [7:0]  pos;
    logic [15:0] crc;
    logic [7:0]  hdrb[6];
    logic [7:0]  crc_lo;
    rx_word_t    expected_words[$];
    int          errors;

    function new();
      sf = 8'd222; ss = 8'd173; esc = 8'd125;
      ver = 8'd1; own = 8'd0; ack = 8'd65;
      foreach (hdrb[i]) hdrb[i] = 8'd0;
      crc_lo = 8'd0;
      errors = 0;
      go_hunt();
    endfunction

    function void go_hunt();
      mode = HUNT_FIRST; esc_pend = 1'b0; pos = 8'd0; crc = 16'd0;
    endfunction

    function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic [15:0] v;
      v = c ^ {8'h00, b};
      repeat (8) v = v[0] ? ((v >> 1) ^ 16'hA001) : (v >> 1);
      return v;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] v);
      case (idx)
        sfr_pkg::REG_START_FIRST:  sf = v;
        sfr_pkg::REG_START_SECOND: ss = v;
        sfr_pkg::REG_ESCAPE:       esc = v;
        sfr_pkg::REG_VERSION:      ver = v;
        sfr_pkg::REG_OWN_ADDR:     own = v;
        sfr_pkg::REG_ACK_KIND:     ack = v;
        default: ;
      endcase
    endfunction

    // Header byte at an unstuffed position, zero when not yet received.
    function logic [7:0] hdr_at(int p);
      if (p < 2 || p > 7 || p >= int'(pos)) return 8'd0;
      return hdrb[p-2];
    endfunction

    function void push_report(logic [2:0] st);
      rx_word_t w;
      w = '0;
      w.item_kind = sfr_pkg::KIND_REPORT;
      w.frame_status = st;
      w.msg_kind = hdr_at(4);
      w.dest_addr = hdr_at(5);
      w.src_addr = hdr_at(6);
      w.key_index = hdr_at(7);
      w.frame_length = hdr_at(3);
      if (st == sfr_pkg::ST_OK) begin
        w.is_ack = (w.msg_kind == ack);
        w.for_this_node = (w.dest_addr == own || w.dest_addr == 8'hFF) &&
                          !(w.is_ack && w.src_addr == own);
      end
      expected_words.push_back(w);
    endfunction

    // Advances the prediction by one accepted line byte.
    function void note_byte(logic [7:0] raw);
      logic [7:0] b;
      rx_word_t w;
      int p, len;
      b = raw;
      if (mode == HUNT_SECOND) begin
        if (b == ss) begin
          crc = crc_next(crc, b); pos = 8'd2; mode = IN_FRAME;
        end else begin
          go_hunt();
        end
        return;
      end
      if (mode != IN_FRAME) begin
        if (b == sf) begin
          go_hunt(); crc = crc_next(16'd0, b); pos = 8'd1; mode = HUNT_SECOND;
        end
        return;
      end
      // A raw start byte aborts the frame, even after an escape.
      if (b == sf || b == ss) begin
        push_report(sfr_pkg::ST_ABORT);
        go_hunt();
        if (b == sf) begin
          crc = crc_next(16'd0, b); pos = 8'd1; mode = HUNT_SECOND;
        end
        return;
      end
      if (!esc_pend && b == esc) begin
        esc_pend = 1'b1;
        return;
      end
      if (esc_pend) begin
        b = b ^ 8'h20; esc_pend = 1'b0;
      end
      p = int'(pos);
      if (p >= 2 && p <= 7) hdrb[p-2] = b;
      pos = 8'(p + 1);
      if (p < 8) begin
        crc = crc_next(crc, b);
        if (p == 3 && b < 8'd58) begin
          push_report(sfr_pkg::ST_BAD_LEN);
          go_hunt();
        end
        return;
      end
      len = int'(hdrb[1]);
      if (p < len - 2) begin
        crc = crc_next(crc, b);
        w = '0;
        w.item_kind = sfr_pkg::KIND_BODY; w.body_index = 8'(p); w.body_value = b;
        expected_words.push_back(w);
      end else if (p == len - 2) begin
        crc_lo = b;
      end else begin
        if (hdrb[0] != ver) push_report(sfr_pkg::ST_BAD_VER);
        else if ({b, crc_lo} != crc) push_report(sfr_pkg::ST_BAD_CRC);
        else push_report(sfr_pkg::ST_OK);
        go_hunt();
      end
    endfunction

    task report_mismatch(string msg);
      $display("%s", msg);
      errors++;
    endtask

    task check(rx_word_t got);
      rx_word_t want;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected output word %h", got));
        return;
      end
      want = expected_words.pop_front();
      if (got.item_kind != want.item_kind)
        report_mismatch($sformatf("mismatch on item_kind: got %0h, expected %0h",
                                  got.item_kind, want.item_kind));
      if (got.body_index != want.body_index)
        report_mismatch($sformatf("mismatch on body_index: got %0h, expected %0h",
                                  got.body_index, want.body_index));
      if (got.body_value != want.body_value)
        report_mismatch($sformatf("mismatch on body_value: got %0h, expected %0h",
                                  got.body_value, want.body_value));
      if (got.frame_status != want.frame_status)
        report_mismatch($sformatf("mismatch on frame_status: got %0h, expected %0h",
                                  got.frame_status, want.frame_status));
      if (got.for_this_node != want.for_this_node)
        report_mismatch($sformatf("mismatch on for_this_node: got %0h, expected %0h",
                                  got.for_this_node, want.for_this_node));
      if (got.is_ack != want.is_ack)
        report_mismatch($sformatf("mismatch on is_ack: got %0h, expected %0h",
                                  got.is_ack, want.is_ack));
      if (got.msg_kind != want.msg_kind)
        report_mismatch($sformatf("mismatch on msg_kind: got %0h, expected %0h",
                                  got.msg_kind, want.msg_kind));
      if (got.dest_addr != want.dest_addr)
        report_mismatch($sformatf("mismatch on dest_addr: got %0h, expected %0h",
                                  got.dest_addr, want.dest_addr));
      if (got.src_addr != want.src_addr)
        report_mismatch($sformatf("mismatch on src_addr: got %0h, expected %0h",
                                  got.src_addr, want.src_addr));
      if (got.key_index != want.key_index)
        report_mismatch($sformatf("mismatch on key_index: got %0h, expected %0h",
                                  got.key_index, want.key_index));
      if (got.frame_length != want.frame_length)
        report_mismatch($sformatf("mismatch on frame_length: got %0h, expected %0h",
                                  got.frame_length, want.frame_length));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rx_word_t    out_word;
  int          cycle_count = 0;
  bit          hold_request = 1'b0;
  int          bytes_sent = 0;
  frame_scoreboard sb = new();

  stuffed_frame_receiver_crc16_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_item_kind(out_word.item_kind), .out_body_index(out_word.body_index),
    .out_body_value(out_word.body_value), .out_frame_status(out_word.frame_status),
    .out_for_this_node(out_word.for_this_node), .out_is_ack(out_word.is_ack),
    .out_msg_kind(out_word.msg_kind), .out_dest_addr(out_word.dest_addr),
    .out_src_addr(out_word.src_addr), .out_key_index(out_word.key_index),
    .out_frame_length(out_word.frame_length)
  );

  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_stuffed_frame_receiver_crc16_unit failed");
      $finish;
    end
  end

  // Sends one line byte after a random gap; returns at the falling edge.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Register write over the APB port; caller makes sure the block is idle.
  task automatic write_reg(logic [2:0] idx, logic [7:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {24'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, v);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic set_config(logic [7:0] f, logic [7:0] s, logic [7:0] e,
                            logic [7:0] v, logic [7:0] o, logic [7:0] a);
    wait_idle();
    write_reg(sfr_pkg::REG_START_FIRST, f);
    write_reg(sfr_pkg::REG_START_SECOND, s);
    write_reg(sfr_pkg::REG_ESCAPE, e);
    write_reg(sfr_pkg::REG_VERSION, v);
    write_reg(sfr_pkg::REG_OWN_ADDR, o);
    write_reg(sfr_pkg::REG_ACK_KIND, a);
  endtask

  // Stuffs one unstuffed byte at frame position two or later.
  task automatic send_stuffed(logic [7:0] v);
    if (v == sb.sf || v == sb.ss || v == sb.esc) begin
      send_byte(sb.esc);
      send_byte(v ^ 8'h20);
    end else begin
      send_byte(v);
    end
  endtask

  // Builds a frame with random content, mostly well formed, and sends it.
  task automatic send_frame();
    logic [7:0] fr[$];
    logic [15:0] c;
    int len, flaw, cut;
    flaw = $urandom_range(0, 19);
    len = ($urandom_range(0, 14) == 0) ? $urandom_range(200, 255) : $urandom_range(58, 64);
    if (flaw == 1) len = $urandom_range(0, 57);
    fr.push_back(sb.sf);
    fr.push_back(sb.ss);
    fr.push_back(flaw == 2 ? sb.ver ^ (8'd1 << $urandom_range(0, 7)) : sb.ver);
    fr.push_back(8'(len));
    fr.push_back($urandom_range(0, 2) == 0 ? sb.ack : 8'($urandom_range(0, 255)));
    case ($urandom_range(0, 2))
      0: fr.push_back(sb.own);
      1: fr.push_back(8'hFF);
      default: fr.push_back(8'($urandom_range(0, 255)));
    endcase
    fr.push_back($urandom_range(0, 1) ? sb.own : 8'($urandom_range(0, 255)));
    fr.push_back(8'($urandom_range(0, 255)));
    while (fr.size() < len - 2) fr.push_back(8'($urandom_range(0, 255)));
    c = 16'd0;
    foreach (fr[i]) c = sb.crc_next(c, fr[i]);
    if (flaw == 3) c = c ^ (16'd1 << $urandom_range(0, 15));
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
    cut = (flaw == 4) ? $urandom_range(2, fr.size() - 1) : fr.size();
    send_byte(fr[0]);
    send_byte(fr[1]);
    for (int i = 2; i < cut; i++) send_stuffed(fr[i]);
    // A cut frame ends in a raw start byte.
    if (flaw == 4) send_byte($urandom_range(0, 1) ? sb.sf : sb.ss);
  endtask

  // Output side: random stalls, and a long hold whenever one is requested.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (hold_request) begin
        hold_request = 1'b0;
        gap = 400;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check(out_word);
    end
  end

  // Main sequence.
  initial begin
    logic [7:0] cfgs[7][6];
    logic [7:0] directed[$];
    int budget;
    cfgs[0] = '{8'd222, 8'd173, 8'd125, 8'd1, 8'd0, 8'd65};
    cfgs[1] = '{8'h00, 8'hFF, 8'h7D, 8'h00, 8'hFF, 8'h00};
    cfgs[2] = '{8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00, 8'hFF};
    cfgs[3] = '{8'h7E, 8'h7E, 8'h7D, 8'h01, 8'h10, 8'h41};
    cfgs[4] = '{8'h55, 8'hAA, 8'h55, 8'h02, 8'h20, 8'h06};
    cfgs[5] = '{8'hC0, 8'hC1, 8'hDB, 8'h80, 8'h7F, 8'h80};
    cfgs[6] = '{8'h00, 8'h01, 8'hFF, 8'h01, 8'h01, 8'h01};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: wrong second byte, bad length, escaped length, abort by
    // each start byte, abort right after an escape.
    directed = '{8'hDE, 8'h00, 8'hDE, 8'hDE, 8'hAD,
                 8'hDE, 8'hAD, 8'h01, 8'h39,
                 8'hDE, 8'hAD, 8'h01, 8'h7D, 8'h1A, 8'h05, 8'hFF, 8'h00, 8'h07, 8'hDE,
                 8'hAD, 8'h7D, 8'hAD,
                 8'hDE, 8'hAD, 8'h01, 8'hFF, 8'hDE, 8'h00};
    foreach (directed[i]) send_byte(directed[i]);

    // Random part, one phase per register setting; the last has fixed start bytes and random other settings.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 7)
        set_config(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2],
                   cfgs[ph][3], cfgs[ph][4], cfgs[ph][5]);
      else
        set_config(8'hA5, 8'h5A, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      budget = bytes_sent + 160;
      while (bytes_sent < budget) begin
        if (ph == 2 && !hold_request && bytes_sent > budget - 120) hold_request = 1'b1;
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        send_frame();
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("tb_stuffed_frame_receiver_crc16_unit passed");
    end else begin
      $display("tb_stuffed_frame_receiver_crc16_unit failed");
    end
    $finish;
  end
endmodule

@@ stuffed_frame_receiver_crc16_unit.f @@
sv/sfr_pkg.sv
sv/sfr_front.sv
sv/sfr_queue.sv
sv/sfr_back.sv
sv/stuffed_frame_receiver_crc16_unit.sv
sim/tb_stuffed_frame_receiver_crc16_unit.sv
